/* design/bvep_pkg.sv */
// Shared types and constants for the vendor beacon element parser.
`default_nettype none

package bvep_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STATION_ID       = 3'd0,
    REG_VENDOR_ID        = 3'd1,
    REG_VENDOR_TAG       = 3'd2,
    REG_PROTOCOL_VERSION = 3'd3,
    REG_UPDATE_FLAG_CODE = 3'd4,
    REG_MAX_ENTRIES      = 3'd5
  } cfg_reg_e;

  // Frame control byte: version bits masked off, must read as a beacon
  localparam logic [7:0] BeaconMask = 8'hFC;
  localparam logic [7:0] BeaconType = 8'h80;

  // Smallest element length that holds the packet header
  localparam logic [7:0] MinElementLen = 8'd7;

  // Byte offsets inside the vendor element, counted from its tag byte
  localparam int unsigned OfsTag      = 0;
  localparam int unsigned OfsLength   = 1;
  localparam int unsigned OfsOui0     = 2;
  localparam int unsigned OfsOui1     = 3;
  localparam int unsigned OfsOui2     = 4;
  localparam int unsigned OfsVersion  = 5;
  localparam int unsigned OfsFlags    = 6;
  localparam int unsigned OfsCtrlData = 7;
  localparam int unsigned OfsCount    = 8;

  localparam int unsigned NumColours  = 5;
  localparam logic [2:0]  LastEntryByte = 3'd5;

  typedef struct packed {
    logic [7:0]  station_id;
    logic [23:0] vendor_id;
    logic [7:0]  vendor_tag;
    logic [7:0]  protocol_version;
    logic [7:0]  update_flag_code;
    logic [5:0]  max_entries;
  } cfg_t;

  // Per-frame parse state (byte position is kept separately, its width varies)
  typedef struct packed {
    logic                          rejected;
    logic [7:0]                    elem_len;
    logic [7:0]                    ctrl_flags;
    logic [7:0]                    ctrl_data;
    logic [7:0]                    declared;
    logic [2:0]                    entry_idx;
    logic [7:0]                    entries_seen;
    logic                          capturing;
    logic                          match_done;
    logic [NumColours-1:0][7:0]    colour;
  } frame_state_t;

endpackage

`default_nettype wire

/* design/bvep_byte_parse.sv */
// Next-state logic for one frame byte: header checks, element fields, entry scan.
`default_nettype none

module bvep_byte_parse
  import bvep_pkg::*;
#(
  parameter int unsigned ELEMENT_OFFSET = 36,
  parameter int unsigned POSITION_WIDTH = 12
) (
  input  logic [POSITION_WIDTH-1:0] pos_i,
  input  logic [7:0]                byte_i,
  input  cfg_t                      cfg_i,
  input  frame_state_t              st_i,
  output logic [POSITION_WIDTH-1:0] pos_o,
  output frame_state_t              st_o
);

  localparam logic [POSITION_WIDTH-1:0] PosMax  = '1;
  localparam logic [POSITION_WIDTH-1:0] ElemOff = POSITION_WIDTH'(ELEMENT_OFFSET);

  logic [POSITION_WIDTH-1:0] rel;
  logic [2:0]                colour_sel;

  assign rel        = pos_i - ElemOff;
  assign colour_sel = st_i.entry_idx - 3'd1;

  always_comb begin
    st_o  = st_i;
    pos_o = pos_i;
    if (pos_i == PosMax) begin
      // counter saturated: frame is too long
      st_o.rejected = 1'b1;
    end else begin
      pos_o = pos_i + POSITION_WIDTH'(1);
      if (pos_i == '0 && (byte_i & BeaconMask) != BeaconType) begin
        st_o.rejected = 1'b1;
      end
      if (pos_i >= ElemOff) begin
        case (rel)
          POSITION_WIDTH'(OfsTag): begin
            if (byte_i != cfg_i.vendor_tag) st_o.rejected = 1'b1;
          end
          POSITION_WIDTH'(OfsLength): begin
            st_o.elem_len = byte_i;
            if (byte_i < MinElementLen) st_o.rejected = 1'b1;
          end
          POSITION_WIDTH'(OfsOui0): begin
            if (byte_i != cfg_i.vendor_id[23:16]) st_o.rejected = 1'b1;
          end
          POSITION_WIDTH'(OfsOui1): begin
            if (byte_i != cfg_i.vendor_id[15:8]) st_o.rejected = 1'b1;
          end
          POSITION_WIDTH'(OfsOui2): begin
            if (byte_i != cfg_i.vendor_id[7:0]) st_o.rejected = 1'b1;
          end
          POSITION_WIDTH'(OfsVersion): begin
            if (byte_i != cfg_i.protocol_version) st_o.rejected = 1'b1;
          end
          POSITION_WIDTH'(OfsFlags): begin
            st_o.ctrl_flags = byte_i;
          end
          POSITION_WIDTH'(OfsCtrlData): begin
            st_o.ctrl_data = byte_i;
          end
          POSITION_WIDTH'(OfsCount): begin
            st_o.declared = byte_i;
            if (byte_i > {2'b00, cfg_i.max_entries}) st_o.rejected = 1'b1;
          end
          default: begin
            // six-byte entries: id, then five colour levels
            if (st_i.entries_seen < st_i.declared) begin
              if (st_i.entry_idx == 3'd0) begin
                if (!st_i.match_done && byte_i == cfg_i.station_id) begin
                  st_o.capturing = 1'b1;
                end
              end else if (st_i.capturing && colour_sel < 3'(NumColours)) begin
                st_o.colour[colour_sel] = byte_i;
              end
              if (st_i.entry_idx >= LastEntryByte) begin
                st_o.entry_idx    = 3'd0;
                st_o.entries_seen = st_i.entries_seen + 8'd1;
                if (st_i.capturing) begin
                  st_o.capturing  = 1'b0;
                  st_o.match_done = 1'b1;
                end
              end else begin
                st_o.entry_idx = st_i.entry_idx + 3'd1;
              end
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* design/beacon_vendor_element_parser_core.sv */
// Top level of the vendor beacon element parser: beat registers, frame verdict, config.
`default_nettype none

// Takes a received frame one byte per beat and, on the beat marked as last,
// delivers one verdict beat: frame_valid, the update request and the colour
// levels of the first entry addressed to station_id. A byte sits in the
// input register, the parse logic updates the frame state, and the verdict
// lands in the output register, so a new byte is taken every cycle while
// the output side is not stalled. The last byte passes through the input
// register and then the verdict register. Configuration writes are
// always ready and take effect on the next byte.

module beacon_vendor_element_parser_core
  import bvep_pkg::*;
#(
  parameter int unsigned ELEMENT_OFFSET = 36,
  parameter int unsigned CHECK_BYTES    = 4,
  parameter int unsigned POSITION_WIDTH = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // verdict
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_valid_o,
  output logic        update_requested_o,
  output logic        entry_found_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  warm_white_o,
  output logic [7:0]  cool_white_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned CmpWidth = POSITION_WIDTH + 2;
  localparam logic [CmpWidth-1:0] HdrEnd   = CmpWidth'(ELEMENT_OFFSET + 2);
  localparam logic [CmpWidth-1:0] ChkBytes = CmpWidth'(CHECK_BYTES);

  cfg_t cfg_q;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  frame_state_t              st_q, st_d;

  logic       out_valid_q;
  logic       frame_valid_q, update_q, found_q;
  logic [NumColours-1:0][7:0] colour_q;

  logic advance;
  logic accept;

  // Handshake: the byte register drains whenever the verdict register can take a beat
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.station_id       <= 8'd0;
      cfg_q.vendor_id        <= 24'd0;
      cfg_q.vendor_tag       <= 8'd221;
      cfg_q.protocol_version <= 8'd1;
      cfg_q.update_flag_code <= 8'd1;
      cfg_q.max_entries      <= 6'd41;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_STATION_ID:       cfg_q.station_id       <= cfg_data_i[7:0];
        REG_VENDOR_ID:        cfg_q.vendor_id        <= cfg_data_i;
        REG_VENDOR_TAG:       cfg_q.vendor_tag       <= cfg_data_i[7:0];
        REG_PROTOCOL_VERSION: cfg_q.protocol_version <= cfg_data_i[7:0];
        REG_UPDATE_FLAG_CODE: cfg_q.update_flag_code <= cfg_data_i[7:0];
        REG_MAX_ENTRIES:      cfg_q.max_entries      <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Input byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  bvep_byte_parse #(
    .ELEMENT_OFFSET(ELEMENT_OFFSET),
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_parse (
    .pos_i (pos_q),
    .byte_i(byte_q),
    .cfg_i (cfg_q),
    .st_i  (st_q),
    .pos_o (pos_d),
    .st_o  (st_d)
  );

  // Frame verdict from the state after this byte
  logic [CmpWidth-1:0] flen, ie_end;
  logic [11:0]         entries_need, entries_room;
  logic                frame_ok, update_ok;

  assign flen         = CmpWidth'(pos_d);
  assign ie_end       = HdrEnd + CmpWidth'(st_d.elem_len);
  assign entries_need = 12'd4 + 12'(st_d.declared) * 12'd6;
  assign entries_room = 12'(st_d.elem_len) - 12'd3;

  assign frame_ok = !st_d.rejected
                 && (flen >= HdrEnd)
                 && (ie_end <= flen)
                 && ((flen == ie_end) || (flen == ie_end + ChkBytes))
                 && (st_d.elem_len >= MinElementLen)
                 && (entries_need <= entries_room);

  assign update_ok = frame_ok
                  && (st_d.ctrl_flags == cfg_q.update_flag_code)
                  && (st_d.ctrl_data == cfg_q.station_id);

  // Frame state: cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      st_q  <= '0;
    end else if (advance) begin
      if (last_q) begin
        pos_q <= '0;
        st_q  <= '0;
      end else begin
        pos_q <= pos_d;
        st_q  <= st_d;
      end
    end
  end

  // Verdict register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      frame_valid_q <= frame_ok;
      update_q      <= update_ok;
      found_q       <= frame_ok && st_d.match_done;
      colour_q      <= (frame_ok && st_d.match_done) ? st_d.colour : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign frame_valid_o      = frame_valid_q;
  assign update_requested_o = update_q;
  assign entry_found_o      = found_q;
  assign red_o              = colour_q[0];
  assign green_o            = colour_q[1];
  assign blue_o             = colour_q[2];
  assign warm_white_o       = colour_q[3];
  assign cool_white_o       = colour_q[4];

endmodule

`default_nettype wire

/* tb/beacon_vendor_element_parser_core_tb.sv */
// Self-checking testbench for the vendor beacon element parser: frame stimulus, verdict scoreboard.
`default_nettype none

module beacon_vendor_element_parser_core_tb;
  import bvep_pkg::*;

  localparam int unsigned ElemOfs    = 36;
  localparam int unsigned CheckBytes = 4;
  localparam int unsigned PosWidth   = 12;
  localparam int unsigned PosMax     = (1 << PosWidth) - 1;

  localparam int CycleLimit   = 1000000;
  localparam int ItemTarget   = 1300;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 8;

  // Ways a generated frame can be broken
  typedef enum int {
    FAULT_NONE,
    FAULT_TYPE,
    FAULT_TAG,
    FAULT_SHORT_LEN,
    FAULT_VENDOR,
    FAULT_VERSION,
    FAULT_COUNT_MAX,
    FAULT_COUNT_FIT,
    FAULT_TRAIL,
    FAULT_TRUNC,
    FAULT_NOISE
  } frame_fault_e;

  // One verdict beat
  typedef struct packed {
    logic                       valid;
    logic                       upd;
    logic                       found;
    logic [NumColours-1:0][7:0] level;
  } verdict_t;

  // Frame parser mirror plus queue of verdicts still owed by the block
  class verdict_board;
    cfg_t                  regs;
    logic [PosWidth-1:0]   pos;
    logic                  rejected;
    logic [7:0]            elem_len;
    logic [7:0]            flags;
    logic [7:0]            ctrl;
    logic [7:0]            declared;
    logic [2:0]            ent_idx;
    logic [7:0]            seen;
    logic                  capturing;
    logic                  matched;
    logic [7:0]            colour [NumColours];
    verdict_t              expected_q[$];
    int                    errors;

    function new();
      regs.station_id       = 8'd0;
      regs.vendor_id        = 24'd0;
      regs.vendor_tag       = 8'd221;
      regs.protocol_version = 8'd1;
      regs.update_flag_code = 8'd1;
      regs.max_entries      = 6'd41;
      errors                = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos       = '0;
      rejected  = 1'b0;
      elem_len  = '0;
      flags     = '0;
      ctrl      = '0;
      declared  = '0;
      ent_idx   = '0;
      seen      = '0;
      capturing = 1'b0;
      matched   = 1'b0;
      foreach (colour[k]) colour[k] = '0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [23:0] d);
      case (idx)
        REG_STATION_ID:       regs.station_id       = d[7:0];
        REG_VENDOR_ID:        regs.vendor_id        = d;
        REG_VENDOR_TAG:       regs.vendor_tag       = d[7:0];
        REG_PROTOCOL_VERSION: regs.protocol_version = d[7:0];
        REG_UPDATE_FLAG_CODE: regs.update_flag_code = d[7:0];
        REG_MAX_ENTRIES:      regs.max_entries      = d[5:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the mirror by one accepted byte; on the last byte queue the verdict
    function void note_byte(logic [7:0] b, logic last);
      int unsigned p;
      int          flen;
      int          ie_end;
      int          el;
      int          slot;
      logic        ok;
      verdict_t    v;
      p = 32'(pos);
      if (p >= PosMax) begin
        rejected = 1'b1;
      end else begin
        if (p == 0 && (b & BeaconMask) != BeaconType) rejected = 1'b1;
        if (p >= ElemOfs) begin
          case (p - ElemOfs)
            OfsTag:      if (b != regs.vendor_tag) rejected = 1'b1;
            OfsLength: begin
              elem_len = b;
              if (b < MinElementLen) rejected = 1'b1;
            end
            OfsOui0:     if (b != regs.vendor_id[23:16]) rejected = 1'b1;
            OfsOui1:     if (b != regs.vendor_id[15:8]) rejected = 1'b1;
            OfsOui2:     if (b != regs.vendor_id[7:0]) rejected = 1'b1;
            OfsVersion:  if (b != regs.protocol_version) rejected = 1'b1;
            OfsFlags:    flags = b;
            OfsCtrlData: ctrl = b;
            OfsCount: begin
              declared = b;
              if (b > regs.max_entries) rejected = 1'b1;
            end
            default: begin
              // entry area: id byte then five levels, only the first match is kept
              if (seen < declared) begin
                if (ent_idx == 0) begin
                  if (!matched && b == regs.station_id) capturing = 1'b1;
                end else if (capturing) begin
                  slot = (int'(ent_idx) - 1) % NumColours;
                  colour[slot] = b;
                end
                if (ent_idx >= LastEntryByte) begin
                  ent_idx = '0;
                  seen    = seen + 8'd1;
                  if (capturing) begin
                    capturing = 1'b0;
                    matched   = 1'b1;
                  end
                end else begin
                  ent_idx = ent_idx + 3'd1;
                end
              end
            end
          endcase
        end
        pos = PosWidth'(p + 1);
      end
      if (!last) return;

      // length rules at end of frame
      flen   = int'(pos);
      el     = int'(elem_len);
      ie_end = ElemOfs + 2 + el;
      ok     = !rejected && flen >= ElemOfs + 2 && ie_end <= flen;
      if (ok) ok = (flen - ie_end == 0) || (flen - ie_end == CheckBytes);
      if (ok) ok = el >= MinElementLen && (4 + 6 * int'(declared) <= el - 3);
      v = '0;
      if (ok) begin
        v.valid = 1'b1;
        v.upd   = (flags == regs.update_flag_code) && (ctrl == regs.station_id);
        if (matched) begin
          v.found = 1'b1;
          for (int k = 0; k < NumColours; k++) v.level[k] = colour[k];
        end
      end
      expected_q.push_back(v);
      clear_frame();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH: %s", msg);
    endtask

    task check_verdict(verdict_t got);
      string    names [NumColours] = '{"red", "green", "blue", "warm_white", "cool_white"};
      verdict_t want;
      if (expected_q.size() == 0) begin
        report("verdict beat with no frame outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (got.valid !== want.valid)
        report($sformatf("frame_valid got %0b want %0b", got.valid, want.valid));
      if (got.upd !== want.upd)
        report($sformatf("update_requested got %0b want %0b", got.upd, want.upd));
      if (got.found !== want.found)
        report($sformatf("entry_found got %0b want %0b", got.found, want.found));
      for (int k = 0; k < NumColours; k++) begin
        if (got.level[k] !== want.level[k])
          report($sformatf("%s got %0h want %0h", names[k], got.level[k], want.level[k]));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        frame_valid_o;
  logic        update_requested_o;
  logic        entry_found_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  warm_white_o;
  logic [7:0]  cool_white_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [23:0] cfg_data_i;

  verdict_board sb = new();
  logic [7:0]   frame_q[$];
  int           bytes_sent  = 0;
  int           burst_left  = 0;
  int           cycle_count = 0;
  logic         hold_now    = 1'b0;
  logic         hold_done   = 1'b0;
  int           rx_mode     = 0;
  int           rx_window   = 0;

  beacon_vendor_element_parser_core #(
    .ELEMENT_OFFSET(ElemOfs),
    .CHECK_BYTES   (CheckBytes),
    .POSITION_WIDTH(PosWidth)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .frame_valid_o     (frame_valid_o),
    .update_requested_o(update_requested_o),
    .entry_found_o     (entry_found_o),
    .red_o             (red_o),
    .green_o           (green_o),
    .blue_o            (blue_o),
    .warm_white_o      (warm_white_o),
    .cool_white_o      (cool_white_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Clock
  always #4 clk_i = ~clk_i;

  // Run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Receiver: one long hold-off when asked, otherwise a changing stall pattern
  always begin
    @(posedge clk_i);
    if (hold_now && !hold_done) begin
      out_stall_i <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_done = 1'b1;
    end else begin
      if (rx_window == 0) begin
        rx_mode   = $urandom_range(0, 3);
        rx_window = $urandom_range(16, 96);
      end
      rx_window--;
      case (rx_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // Verdict monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_verdict('{valid: frame_valid_o, upd: update_requested_o, found: entry_found_o,
                         level: {cool_white_o, warm_white_o, blue_o, green_o, red_o}});
    end
  end

  // One config beat; valid stays high so back-to-back writes need no toggle
  task automatic program_reg(cfg_reg_e idx, logic [23:0] val, int w);
    logic [23:0] mask;
    logic [23:0] word;
    mask = (w >= 24) ? 24'hFFFFFF : ((24'd1 << w) - 24'd1);
    word = (24'($urandom) & ~mask) | (val & mask);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, word);
  endtask

  task automatic apply_setting(cfg_t s);
    program_reg(REG_STATION_ID, 24'(s.station_id), 8);
    program_reg(REG_VENDOR_ID, s.vendor_id, 24);
    program_reg(REG_VENDOR_TAG, 24'(s.vendor_tag), 8);
    program_reg(REG_PROTOCOL_VERSION, 24'(s.protocol_version), 8);
    program_reg(REG_UPDATE_FLAG_CODE, 24'(s.update_flag_code), 8);
    program_reg(REG_MAX_ENTRIES, 24'(s.max_entries), 6);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every owed verdict has come back and the pipe has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  // Send frame_q in bursts with random gaps, or back to back
  task automatic send_frame();
    logic steady;
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < frame_q.size(); i++) begin
      if (!steady && burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
      send_byte(frame_q[i], i == frame_q.size() - 1);
      if (burst_left > 0) burst_left--;
    end
  endtask

  // Build a beacon around the current register values, optionally broken one way
  task automatic build_frame(frame_fault_e fault, int len_hint, int count_hint, int trail_hint);
    cfg_t        c;
    int          len;
    int          cmax;
    int          count;
    int          trail;
    logic [7:0]  b;
    logic [23:0] vid;
    c = sb.regs;
    frame_q.delete();
    if (fault == FAULT_NOISE) begin
      repeat ($urandom_range(1, (len_hint > 0) ? len_hint : 60)) frame_q.push_back(8'($urandom));
      return;
    end
    if (len_hint > 0) len = len_hint;
    else if ($urandom_range(0, 9) == 0) len = $urandom_range(200, 255);
    else len = $urandom_range(7, 45);
    if (fault == FAULT_SHORT_LEN) len = $urandom_range(0, 6);
    cmax = (len < 7) ? 0 : (len - 7) / 6;
    if (cmax > c.max_entries) cmax = c.max_entries;
    count = (count_hint >= 0) ? count_hint : $urandom_range(0, cmax);
    if (fault == FAULT_COUNT_MAX) begin
      if ($urandom_range(0, 7) == 0) count = 255;
      else count = $urandom_range(c.max_entries + 1, c.max_entries + 3);
    end
    if (fault == FAULT_COUNT_FIT) count = (len - 7) / 6 + 1;

    // frame control and the rest of the fixed header
    b = {6'b100000, 2'($urandom)};
    if (fault == FAULT_TYPE) begin
      do b = 8'($urandom); while ((b & BeaconMask) == BeaconType);
    end
    frame_q.push_back(b);
    repeat (ElemOfs - 1) frame_q.push_back(8'($urandom));

    // element header
    b = c.vendor_tag;
    if (fault == FAULT_TAG) b = b ^ 8'($urandom_range(1, 255));
    frame_q.push_back(b);
    frame_q.push_back(8'(len));
    vid = c.vendor_id;
    if (fault == FAULT_VENDOR) vid = vid ^ (24'd1 << $urandom_range(0, 23));
    frame_q.push_back(vid[23:16]);
    frame_q.push_back(vid[15:8]);
    frame_q.push_back(vid[7:0]);
    b = c.protocol_version;
    if (fault == FAULT_VERSION) b = b ^ 8'($urandom_range(1, 255));
    frame_q.push_back(b);
    frame_q.push_back($urandom_range(0, 1) ? c.update_flag_code : 8'($urandom));
    frame_q.push_back($urandom_range(0, 1) ? c.station_id : 8'($urandom));
    frame_q.push_back(8'(count));

    // entries, a fair share addressed to this station; none past the element end
    for (int n = 0; n < count && frame_q.size() + NumColours + 1 <= ElemOfs + 2 + len; n++)
    begin
      frame_q.push_back($urandom_range(0, 1) ? c.station_id : 8'($urandom));
      repeat (NumColours) frame_q.push_back(8'($urandom));
    end
    while (frame_q.size() < ElemOfs + 2 + len) frame_q.push_back(8'($urandom));

    // check bytes
    if (fault == FAULT_TRAIL) begin
      do trail = $urandom_range(1, 8); while (trail == CheckBytes);
    end else if (trail_hint >= 0) begin
      trail = trail_hint;
    end else begin
      trail = $urandom_range(0, 1) * CheckBytes;
    end
    repeat (trail) frame_q.push_back(8'($urandom));
    if (fault == FAULT_TRUNC) repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
  endtask

  task automatic random_frame();
    int r;
    r = $urandom_range(0, 19);
    build_frame((r < 10) ? FAULT_NONE : frame_fault_e'(r - 9), 0, -1, -1);
    send_frame();
  endtask

  // Main sequence
  initial begin
    cfg_t s;
    int   phase;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_STATION_ID;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames under reset register values
    frame_q = '{8'h80};
    send_frame();
    frame_q = '{8'hFF};
    send_frame();
    build_frame(FAULT_NONE, 7, 0, 0);
    send_frame();
    build_frame(FAULT_NONE, 255, 41, CheckBytes);
    send_frame();
    build_frame(FAULT_NONE, 13, 1, 0);
    send_frame();
    for (int f = FAULT_TYPE; f <= FAULT_NOISE; f++) begin
      build_frame(frame_fault_e'(f), 20, -1, -1);
      send_frame();
    end

    // random phases, each under its own register setting
    phase = 1;
    while (phase <= 3 || bytes_sent < ItemTarget) begin
      drain();
      case (phase)
        1: s = '0;
        2: begin
          s = '1;
          s.max_entries = 6'd41;
        end
        default: begin
          s.station_id       = 8'($urandom);
          s.vendor_id        = 24'($urandom);
          s.vendor_tag       = 8'($urandom);
          s.protocol_version = 8'($urandom);
          s.update_flag_code = 8'($urandom);
          s.max_entries      = 6'($urandom_range(0, 41));
        end
      endcase
      apply_setting(s);
      if (phase == 3) begin
        // receiver holds off while tiny frames pile into the block
        hold_now <= 1'b1;
        repeat (30) begin
          build_frame(FAULT_NOISE, 3, -1, -1);
          send_frame();
        end
      end
      repeat ($urandom_range(1, 2)) random_frame();
      phase++;
    end

    drain();
    if (sb.pending() != 0) sb.report($sformatf("%0d verdicts never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
